@@ sv/bldsw_pkg.sv @@
// bldsw_pkg: shared types, register indexes and layout constants for the
// block-linear to linear deswizzle core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bldsw_pkg;

    localparam int ADDR_BITS_DEFAULT = 40;
    localparam int MID_DEPTH_DEFAULT = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ROW_BYTES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_ROWS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_DEPTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_HEIGHT_LOG2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_DEPTH_LOG2  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_ROW_BYTES    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_SLICE_BYTES  = 3'd6;

    // layout limits
    localparam logic [2:0]  MAX_BH_LOG2      = 3'd5;
    localparam logic [11:0] MAX_SLICE_BLOCKS = 12'd2048;
    localparam logic [4:0]  GOB_LAST_CHUNK   = 5'd31;

    // descriptor field widths
    localparam int SLICE_W = 11;
    localparam int ROW_W   = 23;
    localparam int OFF_W   = 19;
    localparam int SUM_MIN_W = 44;

    typedef struct packed {
        logic [17:0] source_row_bytes;
        logic [14:0] surface_rows;
        logic [11:0] surface_depth;
        logic [2:0]  block_height_log2;
        logic [2:0]  block_depth_log2;
        logic [17:0] dest_row_bytes;
        logic [31:0] dest_slice_bytes;
    } cfg_t;

    // one classified chunk, handed from the front to the back
    typedef struct packed {
        logic               write_valid;
        logic               surface_last;
        logic [SLICE_W-1:0] slice;
        logic [ROW_W-1:0]   row;
        logic [OFF_W-1:0]   offset;
        logic [15:0]        byte_enables;
        logic [63:0]        data_low;
        logic [63:0]        data_high;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

@@ sv/bldsw_front.sv @@
// bldsw_front: surface counters and per-chunk classification (row, offset,
// byte enables, last flag). Depends on bldsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bldsw_front
    import bldsw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        accept,
    input  wire logic [63:0] chunk_low,
    input  wire logic [63:0] chunk_high,
    output desc_t            desc
);

    logic [10:0] slice_reg, slice_next;
    logic [13:0] rowb_reg, rowb_next;
    logic [12:0] col_reg, col_next;
    logic [4:0]  gob_reg, gob_next;
    logic [4:0]  chunk_reg, chunk_next;

    logic [2:0]  bh;
    logic [5:0]  gobs;
    logic [8:0]  block_rows;
    logic [12:0] xb;
    logic [15:0] yb_sum;
    logic [12:0] yb;
    logic [11:0] zb_raw;
    logic [11:0] zb;
    logic        empty_surface;

    logic [2:0]  local_y;
    logic [5:0]  local_x;
    logic [19:0] gob_line;
    logic [ROW_W-1:0] row;
    logic [18:0] x;
    logic        row_ok;
    logic [18:0] diff;
    logic [6:0]  len;
    logic [15:0] be;

    logic end_c, end_g, end_x, end_y, end_z;

    // layout sizes from the configuration
    always_comb
    begin
        bh         = (cfg.block_height_log2 > MAX_BH_LOG2) ? MAX_BH_LOG2
                                                           : cfg.block_height_log2;
        gobs       = 6'd1 << bh;
        block_rows = 9'd8 << bh;
        xb         = 13'((19'(cfg.source_row_bytes) + 19'd63) >> 6);
        yb_sum     = 16'(cfg.surface_rows) + 16'(block_rows) - 16'd1;
        yb         = 13'(yb_sum >> (4'(bh) + 4'd3));
        zb_raw     = cfg.surface_depth >> cfg.block_depth_log2;
        zb         = (zb_raw > MAX_SLICE_BLOCKS) ? MAX_SLICE_BLOCKS : zb_raw;
        empty_surface = (xb == 13'd0) || (yb == 13'd0) || (zb == 12'd0);
    end

    // chunk position inside the GOB and on the surface
    always_comb
    begin
        local_y  = {chunk_reg[3], chunk_reg[2], chunk_reg[0]};
        local_x  = {chunk_reg[4], chunk_reg[1], 4'd0};
        gob_line = (20'(rowb_reg) << bh) + 20'(gob_reg);
        row      = {gob_line, local_y};
        x        = {col_reg, 6'd0};
        row_ok   = row < ROW_W'(cfg.surface_rows);
        diff     = 19'(cfg.dest_row_bytes) - x;
        if (19'(cfg.dest_row_bytes) > x)
        begin
            len = (diff >= 19'd64) ? 7'd64 : diff[6:0];
        end
        else
        begin
            len = 7'd0;
        end
        for (int n = 0; n < 16; n++)
        begin
            be[n] = (7'(local_x) + 7'(n)) < len;
        end
    end

    always_comb
    begin
        end_c = chunk_reg == GOB_LAST_CHUNK;
        end_g = (6'(gob_reg) + 6'd1) >= gobs;
        end_x = (14'(col_reg) + 14'd1) >= 14'(xb);
        end_y = (15'(rowb_reg) + 15'd1) >= 15'(yb);
        end_z = (12'(slice_reg) + 12'd1) >= zb;
    end

    always_comb
    begin
        desc.data_low     = chunk_low;
        desc.data_high    = chunk_high;
        desc.slice        = slice_reg;
        desc.row          = row;
        desc.offset       = {col_reg, local_x};
        desc.write_valid  = !empty_surface && row_ok;
        desc.byte_enables = (!empty_surface && row_ok) ? be : 16'd0;
        desc.surface_last = empty_surface || (end_c && end_g && end_x && end_y && end_z);
    end

    // nested counter step
    always_comb
    begin
        slice_next = slice_reg;
        rowb_next  = rowb_reg;
        col_next   = col_reg;
        gob_next   = gob_reg;
        chunk_next = chunk_reg;
        if (empty_surface)
        begin
            slice_next = '0;
            rowb_next  = '0;
            col_next   = '0;
            gob_next   = '0;
            chunk_next = '0;
        end
        else if (!end_c)
        begin
            chunk_next = chunk_reg + 5'd1;
        end
        else
        begin
            chunk_next = '0;
            if (!end_g)
            begin
                gob_next = gob_reg + 5'd1;
            end
            else
            begin
                gob_next = '0;
                if (!end_x)
                begin
                    col_next = col_reg + 13'd1;
                end
                else
                begin
                    col_next = '0;
                    if (!end_y)
                    begin
                        rowb_next = rowb_reg + 14'd1;
                    end
                    else
                    begin
                        rowb_next  = '0;
                        slice_next = end_z ? 11'd0 : slice_reg + 11'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= '0;
            rowb_reg  <= '0;
            col_reg   <= '0;
            gob_reg   <= '0;
            chunk_reg <= '0;
        end
        else if (accept)
        begin
            slice_reg <= slice_next;
            rowb_reg  <= rowb_next;
            col_reg   <= col_next;
            gob_reg   <= gob_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/bldsw_queue.sv @@
// bldsw_queue: short descriptor queue between front and back.
// Depends on bldsw_pkg (desc_t, q_status_t). DEPTH must be 2 or more.
`timescale 1ns / 1ps
`default_nettype none

module bldsw_queue
    import bldsw_pkg::*;
#(
    parameter int DEPTH = MID_DEPTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire desc_t wr_data,
    input  wire logic  rd_en,
    output desc_t      rd_data,
    output q_status_t  status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
        status.full  = count_reg == CNT_W'(DEPTH);
        status.empty = count_reg == '0;
        rd_data      = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/bldsw_back.sv @@
// bldsw_back: address pipeline (pitch multiplies, then sum) and result register.
// Depends on bldsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bldsw_back
    import bldsw_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire desc_t                q_data,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      write_valid,
    output logic [ADDR_BITS-1:0]      linear_address,
    output logic [15:0]               byte_enables,
    output logic [63:0]               data_low,
    output logic [63:0]               data_high,
    output logic                      surface_last
);

    localparam int SUM_W = (ADDR_BITS > SUM_MIN_W) ? ADDR_BITS : SUM_MIN_W;

    // multiply stage
    logic        a_valid_reg;
    desc_t       a_desc_reg;
    logic [42:0] a_slice_prod_reg;
    logic [40:0] a_row_prod_reg;

    // result register
    logic                 out_valid_reg;
    logic                 write_valid_reg;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [15:0]          be_reg;
    logic [63:0]          data_low_reg;
    logic [63:0]          data_high_reg;
    logic                 last_reg;

    logic             out_adv;
    logic             a_adv;
    logic [SUM_W-1:0] sum;

    always_comb
    begin
        out_adv = !out_valid_reg || pop;
        a_adv   = !a_valid_reg || out_adv;
        q_pop   = !q_empty && a_adv;
        sum     = SUM_W'(a_slice_prod_reg) + SUM_W'(a_row_prod_reg)
                + SUM_W'(a_desc_reg.offset);
        addr_next = a_desc_reg.write_valid ? sum[ADDR_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= q_pop;
            end
            if (out_adv)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_desc_reg       <= q_data;
            a_slice_prod_reg <= 43'(q_data.slice) * 43'(cfg.dest_slice_bytes);
            a_row_prod_reg   <= 41'(q_data.row) * 41'(cfg.dest_row_bytes);
        end
        if (a_valid_reg && out_adv)
        begin
            write_valid_reg <= a_desc_reg.write_valid;
            addr_reg        <= addr_next;
            be_reg          <= a_desc_reg.byte_enables;
            data_low_reg    <= a_desc_reg.data_low;
            data_high_reg   <= a_desc_reg.data_high;
            last_reg        <= a_desc_reg.surface_last;
        end
    end

    assign empty          = !out_valid_reg;
    assign write_valid    = write_valid_reg;
    assign linear_address = addr_reg;
    assign byte_enables   = be_reg;
    assign data_low       = data_low_reg;
    assign data_high      = data_high_reg;
    assign surface_last   = last_reg;

`ifndef SYNTHESIS
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !write_valid_reg |-> addr_reg == '0 && be_reg == 16'd0)
        else $error("non-written chunk carries address or byte enables");

    a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !out_adv |=> a_valid_reg && $stable(a_row_prod_reg)
            && $stable(a_slice_prod_reg))
        else $error("multiply stage lost or changed a stalled item");

    a_pop_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> a_valid_reg)
        else $error("item popped from queue did not reach multiply stage");
`endif

endmodule

`default_nettype wire

@@ sv/block_linear_to_linear_deswizzle_core.sv @@
// Block-linear to linear deswizzle core: one 16-byte chunk per cycle sustained while pop keeps up.
// Path: an accepted item is written into the queue, moves to the multiply stage,
// then its address sum goes into the result register; stages hold while pop is low.
// Throughput: one item per cycle while pop keeps up; the front counters step once per chunk.
// Reset (rst_n, async low): counters, queue and valid flags clear, config regs
// return to their defaults; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module block_linear_to_linear_deswizzle_core
    import bldsw_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT,
    parameter int MID_DEPTH = MID_DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // chunk input queue side
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [63:0]            chunk_low,
    input  wire logic [63:0]            chunk_high,
    // result queue side
    output logic                        empty,
    input  wire logic                   pop,
    output logic                        write_valid,
    output logic [ADDR_BITS-1:0]        linear_address,
    output logic [15:0]                 byte_enables,
    output logic [63:0]                 data_low,
    output logic [63:0]                 data_high,
    output logic                        surface_last
);

    cfg_t      cfg_reg;
    desc_t     front_desc;
    desc_t     q_data;
    q_status_t q_status;
    logic      accept;
    logic      q_pop;

    // Config regs. The user must write them only while the pipe is drained; the block
    // does not enforce it. Front and back read them straight, without a shadow copy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_row_bytes  <= 18'd64;
            cfg_reg.surface_rows      <= 15'd8;
            cfg_reg.surface_depth     <= 12'd1;
            cfg_reg.block_height_log2 <= 3'd0;
            cfg_reg.block_depth_log2  <= 3'd0;
            cfg_reg.dest_row_bytes    <= 18'd64;
            cfg_reg.dest_slice_bytes  <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_ROW_BYTES:  cfg_reg.source_row_bytes  <= cfg_data[17:0];
                REG_SURFACE_ROWS:      cfg_reg.surface_rows      <= cfg_data[14:0];
                REG_SURFACE_DEPTH:     cfg_reg.surface_depth     <= cfg_data[11:0];
                REG_BLOCK_HEIGHT_LOG2: cfg_reg.block_height_log2 <= cfg_data[2:0];
                REG_BLOCK_DEPTH_LOG2:  cfg_reg.block_depth_log2  <= cfg_data[2:0];
                REG_DEST_ROW_BYTES:    cfg_reg.dest_row_bytes    <= cfg_data[17:0];
                REG_DEST_SLICE_BYTES:  cfg_reg.dest_slice_bytes  <= cfg_data[31:0];
                default:               ;
            endcase
        end
    end

    // Input side looks like a queue: full only when the middle queue is full.
    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // Front: walks the z/y/x/GOB-row/chunk counters and classifies each chunk.
    bldsw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .chunk_low  (chunk_low),
        .chunk_high (chunk_high),
        .desc       (front_desc)
    );

    // Middle queue decouples the counters from the address pipeline.
    bldsw_queue #(
        .DEPTH (MID_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_desc),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    // Back: slice*slice_pitch and row*row_pitch, then the address sum.
    bldsw_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_data         (q_data),
        .q_empty        (q_status.empty),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .write_valid    (write_valid),
        .linear_address (linear_address),
        .byte_enables   (byte_enables),
        .data_low       (data_low),
        .data_high      (data_high),
        .surface_last   (surface_last)
    );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// testbench: self-checking bench for block_linear_to_linear_deswizzle_core.
// Walks a short directed plan, then random chunk streams under random settings.
// Depends on bldsw_pkg and the core; reads nothing else.
`timescale 1ns / 1ps

module testbench;
    import bldsw_pkg::*;

    localparam int ADDR_W           = ADDR_BITS_DEFAULT;
    localparam int RANDOM_ITEMS     = 800;
    localparam int QUIET_ITEMS      = 100;  // closing stretch with no idling
    localparam int SINK_HOLD_CYCLES = 48;   // long receiver hold, fills the core
    localparam int TIMEOUT_NS       = 2_000_000;
    localparam int PLAN_ROWS        = 25;

    localparam logic [63:0] ZEROS = '0;
    localparam logic [63:0] ONES  = '1;
    localparam logic [63:0] ALT5  = {16{4'h5}};
    localparam logic [63:0] ALTA  = {16{4'hA}};

    // index field of an item row carries no meaning
    localparam logic [CFG_INDEX_W-1:0] NO_REG = '0;

    // one result item as it leaves the core
    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] linear_address;
        logic [15:0]       byte_enables;
        logic [63:0]       data_low;
        logic [63:0]       data_high;
        logic              surface_last;
    } chunk_write_t;

    // hand-written expectation for a directed row; typed = 0 means predicted
    typedef struct packed {
        logic              typed;
        logic              write_valid;
        logic [ADDR_W-1:0] linear_address;
        logic [15:0]       byte_enables;
        logic              surface_last;
    } want_t;

    typedef enum logic {STEP_ITEMS, STEP_WRITE} step_kind_t;

    typedef struct packed {
        step_kind_t             kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
        logic [15:0]            count;
        logic [63:0]            lo;
        logic [63:0]            hi;
        want_t                  want;
    } plan_row_t;

    localparam want_t NO_WANT = '0;

    // Directed plan, starting from reset settings (64-byte rows, 8 rows, one
    // slice, one GOB per block): first a 32-chunk surface, then register edge cases.
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // first chunk, all-zero data
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd1, ZEROS, ZEROS, '{1'b1, 1'b1, 40'd0, 16'hFFFF, 1'b0}},
        // chunk 1 sits on row 1, column 0
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd1, ONES, ONES, '{1'b1, 1'b1, 40'd64, 16'hFFFF, 1'b0}},
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd29, ALT5, ALTA, NO_WANT},
        // chunk 31: row 7, column 48, end of surface
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd1, ALTA, ALT5, '{1'b1, 1'b1, 40'd496, 16'hFFFF, 1'b1}},
        // zero destination pitch: row still valid, no byte enabled
        '{STEP_WRITE, REG_DEST_ROW_BYTES, 32'd0, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd1, ONES, ZEROS, '{1'b1, 1'b1, 40'd0, 16'h0000, 1'b0}},
        // partial row width and rows past the surface
        '{STEP_WRITE, REG_DEST_ROW_BYTES, 32'd40, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_SURFACE_ROWS, 32'd1, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd16, ZEROS, ONES, NO_WANT},
        // every register but block depth at its top value, mid-surface; block height saturates
        '{STEP_WRITE, REG_DEST_SLICE_BYTES, 32'hFFFF_FFFF, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_SURFACE_DEPTH, 32'd4095, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_BLOCK_HEIGHT_LOG2, 32'd7, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_SOURCE_ROW_BYTES, 32'h3FFFF, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_SURFACE_ROWS, 32'h7FFF, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_DEST_ROW_BYTES, 32'h3FFFF, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd4, ONES, ZEROS, NO_WANT},
        // empty surface three ways: no columns, no rows, no slice blocks
        '{STEP_WRITE, REG_SOURCE_ROW_BYTES, 32'd0, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd2, ZEROS, ONES, '{1'b1, 1'b0, 40'd0, 16'h0000, 1'b1}},
        '{STEP_WRITE, REG_SOURCE_ROW_BYTES, 32'd64, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_SURFACE_ROWS, 32'd0, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd1, ALT5, ALT5, '{1'b1, 1'b0, 40'd0, 16'h0000, 1'b1}},
        '{STEP_WRITE, REG_SURFACE_ROWS, 32'd8, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_SURFACE_DEPTH, 32'd3, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_WRITE, REG_BLOCK_DEPTH_LOG2, 32'd2, 16'd0, ZEROS, ZEROS, NO_WANT},
        '{STEP_ITEMS, NO_REG, 32'd0, 16'd1, ALTA, ALTA, '{1'b1, 1'b0, 40'd0, 16'h0000, 1'b1}}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   push;
    logic                   full;
    logic [63:0]            chunk_low;
    logic [63:0]            chunk_high;
    logic                   empty;
    logic                   pop;
    logic                   write_valid;
    logic [ADDR_W-1:0]      linear_address;
    logic [15:0]            byte_enables;
    logic [63:0]            data_low;
    logic [63:0]            data_high;
    logic                   surface_last;

    // Predictor state: a copy of the register file and the surface walk counters
    cfg_t        surface_cfg;
    logic [10:0] slice_blk;
    logic [13:0] row_blk;
    logic [12:0] col_blk;
    logic [4:0]  gob_row;
    logic [4:0]  chunk_in_gob;

    chunk_write_t pending_writes [$];   // expected results, oldest first
    chunk_write_t oldest;
    int           mismatches;
    bit           quiet;                // no idling on either side
    bit           sink_hold_req;        // ask the receiver for one long hold

    block_linear_to_linear_deswizzle_core #(
        .ADDR_BITS (ADDR_W)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .chunk_low      (chunk_low),
        .chunk_high     (chunk_high),
        .empty          (empty),
        .pop            (pop),
        .write_valid    (write_valid),
        .linear_address (linear_address),
        .byte_enables   (byte_enables),
        .data_low       (data_low),
        .data_high      (data_high),
        .surface_last   (surface_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // Where a chunk lands in the linear surface. Advances the walk counters by
    // one chunk, exactly as the core does on each accepted item.
    function automatic chunk_write_t deswizzle_chunk(input logic [63:0] lo,
                                                     input logic [63:0] hi);
        int unsigned  bh, gobs, block_rows, xb, yb, zb, idx, local_y, local_x, n;
        logic [63:0]  row, x, len, addr;
        logic         end_c, end_g, end_x, end_y, end_z;
        chunk_write_t r;
        r = '0;
        r.data_low = lo;
        r.data_high = hi;
        bh = (surface_cfg.block_height_log2 > MAX_BH_LOG2) ? MAX_BH_LOG2
                                                           : surface_cfg.block_height_log2;
        gobs = 1 << bh;
        block_rows = 8 << bh;
        xb = (surface_cfg.source_row_bytes + 32'd63) >> 6;
        yb = (surface_cfg.surface_rows + block_rows - 1) / block_rows;
        zb = surface_cfg.surface_depth >> surface_cfg.block_depth_log2;
        if (zb > MAX_SLICE_BLOCKS)
            zb = MAX_SLICE_BLOCKS;

        // nothing to walk: every chunk closes the surface and writes nothing
        if (xb == 0 || yb == 0 || zb == 0)
        begin
            slice_blk = '0;
            row_blk = '0;
            col_blk = '0;
            gob_row = '0;
            chunk_in_gob = '0;
            r.surface_last = 1'b1;
            return r;
        end

        // chunk order inside a GOB: row bits {i[3:2], i[0]}, column bits {i[4], i[1]}
        idx = chunk_in_gob;
        local_y = ((idx >> 1) & 6) | (idx & 1);
        local_x = ((idx << 3) & 16) | ((idx << 1) & 32);
        row = row_blk;
        row = ((row << bh) + gob_row) * 8 + local_y;
        x = col_blk * 64;

        if (row < surface_cfg.surface_rows)
        begin
            r.write_valid = 1'b1;
            addr = slice_blk;
            addr = addr * surface_cfg.dest_slice_bytes + row * surface_cfg.dest_row_bytes
                   + x + local_x;
            r.linear_address = addr[ADDR_W-1:0];
            // bytes left in the destination row from this GOB, clamped to a GOB
            len = (surface_cfg.dest_row_bytes > x) ? surface_cfg.dest_row_bytes - x : 64'd0;
            if (len > 64)
                len = 64;
            for (n = 0; n < 16; n++)
                if (local_x + n < len)
                    r.byte_enables[n] = 1'b1;
        end

        // a counter at or past its bound counts as finished
        end_c = (chunk_in_gob >= GOB_LAST_CHUNK);
        end_g = (gob_row + 1 >= gobs);
        end_x = (col_blk + 1 >= xb);
        end_y = (row_blk + 1 >= yb);
        end_z = (slice_blk + 1 >= zb);
        r.surface_last = end_c && end_g && end_x && end_y && end_z;

        if (!end_c)
            chunk_in_gob = chunk_in_gob + 1;
        else
        begin
            chunk_in_gob = '0;
            if (!end_g)
                gob_row = gob_row + 1;
            else
            begin
                gob_row = '0;
                if (!end_x)
                    col_blk = col_blk + 1;
                else
                begin
                    col_blk = '0;
                    if (!end_y)
                        row_blk = row_blk + 1;
                    else
                    begin
                        row_blk = '0;
                        slice_blk = end_z ? 11'd0 : slice_blk + 1;
                    end
                end
            end
        end
        return r;
    endfunction

    // Offer one item until it is taken, then record what it must produce.
    // A random gap sometimes follows it, and push never drops and rises in
    // the same step.
    task automatic send_chunk(input logic [63:0] lo, input logic [63:0] hi,
                              input want_t want);
        chunk_write_t predicted;
        push <= 1'b1;
        chunk_low <= lo;
        chunk_high <= hi;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predicted = deswizzle_chunk(lo, hi);
        if (want.typed)
        begin
            predicted.write_valid = want.write_valid;
            predicted.linear_address = want.linear_address;
            predicted.byte_enables = want.byte_enables;
            predicted.surface_last = want.surface_last;
        end
        pending_writes.push_back(predicted);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    // Register write: only once the core has handed back every chunk.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        push <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (index)
            REG_SOURCE_ROW_BYTES:  surface_cfg.source_row_bytes = value[17:0];
            REG_SURFACE_ROWS:      surface_cfg.surface_rows = value[14:0];
            REG_SURFACE_DEPTH:     surface_cfg.surface_depth = value[11:0];
            REG_BLOCK_HEIGHT_LOG2: surface_cfg.block_height_log2 = value[2:0];
            REG_BLOCK_DEPTH_LOG2:  surface_cfg.block_depth_log2 = value[2:0];
            REG_DEST_ROW_BYTES:    surface_cfg.dest_row_bytes = value[17:0];
            REG_DEST_SLICE_BYTES:  surface_cfg.dest_slice_bytes = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: every taken item is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t ns: result item with nothing expected, address %h",
                         $time, linear_address);
                mismatches++;
            end
            else
            begin
                oldest = pending_writes.pop_front();
                check_field("write_valid", oldest.write_valid, write_valid);
                check_field("linear_address", oldest.linear_address, linear_address);
                check_field("byte_enables", oldest.byte_enables, byte_enables);
                check_field("data_low", oldest.data_low, data_low);
                check_field("data_high", oldest.data_high, data_high);
                check_field("surface_last", oldest.surface_last, surface_last);
            end
        end
    end

    // Receiver: random idle gaps between pops, one long hold on
    // request, and steady popping once the run goes quiet.
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                pop <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1)
                    @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 3))
                    @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // Stimulus: directed plan, then random settings with random chunk streams
    initial
    begin
        int unsigned random_sent;
        int unsigned phase_items;
        int unsigned pick;
        want_t       want;
        bit          first_phase;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= NO_REG;
        cfg_data <= '0;
        push <= 1'b0;
        chunk_low <= '0;
        chunk_high <= '0;
        mismatches = 0;
        quiet = 1'b0;
        sink_hold_req = 1'b0;
        surface_cfg = '{source_row_bytes: 18'd64, surface_rows: 15'd8, surface_depth: 12'd1,
                        block_height_log2: 3'd0, block_depth_log2: 3'd0,
                        dest_row_bytes: 18'd64, dest_slice_bytes: 32'd0};
        slice_blk = '0;
        row_blk = '0;
        col_blk = '0;
        gob_row = '0;
        chunk_in_gob = '0;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[k])
        begin
            if (PLAN[k].kind == STEP_WRITE)
                write_reg(PLAN[k].index, PLAN[k].value);
            else
            begin
                want = PLAN[k].want;
                repeat (PLAN[k].count)
                    send_chunk(PLAN[k].lo, PLAN[k].hi, want);
            end
        end

        // Random phases. Settings are mostly small so surfaces close often;
        // now and then a register goes to zero, to its top or anywhere in range.
        // A new setting can land mid-surface, which also drives the wrap of
        // counters left beyond their new bound.
        random_sent = 0;
        first_phase = 1'b1;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            write_reg(REG_SOURCE_ROW_BYTES,
                      (pick == 0) ? 32'd0 : (pick == 1) ? 32'h3FFFF :
                      (pick == 2) ? $urandom_range(0, 32'h3FFFF) : $urandom_range(1, 130));
            pick = $urandom_range(0, 9);
            write_reg(REG_SURFACE_ROWS,
                      (pick == 0) ? 32'd0 : (pick == 1) ? $urandom_range(0, 32'h7FFF) :
                      $urandom_range(1, 20));
            pick = $urandom_range(0, 9);
            write_reg(REG_SURFACE_DEPTH,
                      (pick == 0) ? 32'd0 : (pick == 1) ? $urandom_range(0, 32'hFFF) :
                      $urandom_range(1, 3));
            write_reg(REG_BLOCK_HEIGHT_LOG2, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 7) : $urandom_range(0, 1));
            write_reg(REG_BLOCK_DEPTH_LOG2, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 7) : 32'd0);
            pick = $urandom_range(0, 9);
            write_reg(REG_DEST_ROW_BYTES,
                      (pick == 0) ? 32'd0 : (pick == 1) ? $urandom_range(0, 32'h3FFFF) :
                      $urandom_range(0, 200));
            write_reg(REG_DEST_SLICE_BYTES, $urandom);

            // first phase: receiver stalls long while items keep coming,
            // so the core fills up and raises full
            if (first_phase)
            begin
                phase_items = 120;
                sink_hold_req = 1'b1;
                first_phase = 1'b0;
            end
            else
                phase_items = $urandom_range(20, 150);
            if (phase_items > RANDOM_ITEMS - random_sent)
                phase_items = RANDOM_ITEMS - random_sent;

            if (random_sent + QUIET_ITEMS >= RANDOM_ITEMS)
                quiet = 1'b1;
            repeat (phase_items)
                send_chunk({$urandom, $urandom}, {$urandom, $urandom}, NO_WANT);
            random_sent += phase_items;
        end

        // drain, then leave room for any stray result item
        push <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
